/* rtl/sync_word_frame_deframer_unit_defines.svh */
// assertion macros for the sync word frame deframer
`ifndef SYNC_WORD_FRAME_DEFRAMER_UNIT_DEFINES_SVH
`define SYNC_WORD_FRAME_DEFRAMER_UNIT_DEFINES_SVH

`ifndef SYNTH
`define SWFD_ASSERT_SAME(label, cond, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error("swfd check failed: label");
`define SWFD_ASSERT_NEXT(label, cond, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error("swfd check failed: label");
`else
`define SWFD_ASSERT_SAME(label, cond, prop)
`define SWFD_ASSERT_NEXT(label, cond, prop)
`endif

`endif

/* rtl/swfd_pkg.sv */
// types and constants shared by the deframer files
`timescale 1ns / 1ps
`default_nettype none

package swfd_pkg;

   localparam int BYTE_W     = 8;
   localparam int SAMPLE_W   = 32;
   localparam int INDEX_W    = 32;
   localparam int DECIM_W    = 10;
   localparam int CSR_DATA_W = 10;
   localparam int CSR_IDX_W  = 2;
   localparam int COUNT_W    = 3;

   localparam logic [31:0]        SYNC_WORD     = 32'hEFBE_ADDE;
   localparam logic [COUNT_W-1:0] LAST_PAYLOAD  = 3'd7;
   localparam logic [DECIM_W-1:0] DECIM_DEFAULT = 10'd10;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ENABLE        = 2'd0,
      CSR_INVERT_FIRST  = 2'd1,
      CSR_INVERT_SECOND = 2'd2,
      CSR_DECIMATION    = 2'd3
   } csr_index_type;

endpackage

`default_nettype wire

/* rtl/swfd_req_if.sv */
// byte input channel
`timescale 1ns / 1ps
`default_nettype none

interface swfd_req_if;
   logic                           valid;
   logic                           ready;
   logic [swfd_pkg::BYTE_W-1:0]    data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

`default_nettype wire

/* rtl/swfd_rsp_if.sv */
// frame result channel
`timescale 1ns / 1ps
`default_nettype none

interface swfd_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [swfd_pkg::SAMPLE_W-1:0]  first_sample;
   logic signed [swfd_pkg::SAMPLE_W-1:0]  second_sample;
   logic        [swfd_pkg::INDEX_W-1:0]   frame_index;
   logic                                  display_point;

   modport source (output valid, output first_sample, output second_sample,
                   output frame_index, output display_point, input ready);
   modport sink   (input valid, input first_sample, input second_sample,
                   input frame_index, input display_point, output ready);
endinterface

`default_nettype wire

/* rtl/sync_word_frame_deframer_unit.sv */
// a byte is registered, then processed; a frame result is registered when its last byte is processed
// throughput: one byte per cycle, held back only while a finished result waits in the output register
// the input register and the result register decouple the two channels
// reset (synchronous, active high): disabled, hunting sync, counters zero, decimation 10
`timescale 1ns / 1ps
`default_nettype none
`include "sync_word_frame_deframer_unit_defines.svh"

module sync_word_frame_deframer_unit (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   swfd_req_if.sink                                   req_ch,
   swfd_rsp_if.source                                 rsp_ch,
   input  wire logic                                  csr_wr_en,
   input  wire logic [swfd_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire logic [swfd_pkg::CSR_DATA_W-1:0]       csr_wr_data
);

   logic                               enable_ff;
   logic                               invert_first_ff;
   logic                               invert_second_ff;
   logic [swfd_pkg::DECIM_W-1:0]       decimation_ff;

   logic                               byte_valid_ff;
   logic [swfd_pkg::BYTE_W-1:0]        byte_ff;

   logic [31:0]                        sync_window_ff, sync_window_in;
   logic                               in_frame_ff, in_frame_in;
   logic [swfd_pkg::COUNT_W-1:0]       payload_count_ff, payload_count_in;
   logic [63:0]                        payload_shift_ff, payload_shift_in;
   logic [swfd_pkg::INDEX_W-1:0]       frame_count_ff;
   logic [swfd_pkg::DECIM_W-1:0]       decimation_count_ff, decimation_count_in;

   logic                               rsp_valid_ff;
   logic signed [swfd_pkg::SAMPLE_W-1:0] first_sample_ff, second_sample_ff;
   logic [swfd_pkg::INDEX_W-1:0]       frame_index_ff;
   logic                               display_point_ff;

   logic                               active;
   logic                               frame_done;
   logic                               out_free;
   logic                               advance;
   logic                               rsp_load;
   logic [31:0]                        window_shifted;
   logic [swfd_pkg::DECIM_W:0]         decimation_sum;
   logic                               flag;
   logic [swfd_pkg::SAMPLE_W-1:0]      raw_first, raw_second;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff        <= 1'b0;
         invert_first_ff  <= 1'b0;
         invert_second_ff <= 1'b0;
         decimation_ff    <= swfd_pkg::DECIM_DEFAULT;
      end else if (csr_wr_en) begin
         unique case (swfd_pkg::csr_index_type'(csr_index))
            swfd_pkg::CSR_ENABLE:        enable_ff        <= csr_wr_data[0];
            swfd_pkg::CSR_INVERT_FIRST:  invert_first_ff  <= csr_wr_data[0];
            swfd_pkg::CSR_INVERT_SECOND: invert_second_ff <= csr_wr_data[0];
            swfd_pkg::CSR_DECIMATION:    decimation_ff    <= csr_wr_data;
            default: ;
         endcase
      end
   end

   assign active     = byte_valid_ff && enable_ff;
   assign frame_done = active && in_frame_ff && (payload_count_ff == swfd_pkg::LAST_PAYLOAD);
   assign out_free   = !rsp_valid_ff || rsp_ch.ready;
   assign advance    = !frame_done || out_free;
   assign rsp_load   = frame_done && out_free;
   assign req_ch.ready = !byte_valid_ff || advance;

   // frame processing
   always_comb begin
      window_shifted      = {sync_window_ff[23:0], byte_ff};
      sync_window_in      = sync_window_ff;
      in_frame_in         = in_frame_ff;
      payload_count_in    = payload_count_ff;
      payload_shift_in    = payload_shift_ff;
      decimation_count_in = decimation_count_ff;
      decimation_sum      = {1'b0, decimation_count_ff} + 11'd1;
      flag                = decimation_sum >= {1'b0, decimation_ff};
      raw_first           = payload_shift_ff[39:8];
      raw_second          = {byte_ff, payload_shift_ff[63:40]};
      if (active && advance) begin
         if (!in_frame_ff) begin
            if (window_shifted == swfd_pkg::SYNC_WORD) begin
               sync_window_in   = '0;
               in_frame_in      = 1'b1;
               payload_count_in = '0;
            end else begin
               sync_window_in = window_shifted;
            end
         end else begin
            payload_shift_in = {byte_ff, payload_shift_ff[63:8]};
            payload_count_in = payload_count_ff + 3'd1;
            if (frame_done) begin
               in_frame_in         = 1'b0;
               decimation_count_in = flag ? '0 : decimation_sum[swfd_pkg::DECIM_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_valid_ff       <= 1'b0;
         sync_window_ff      <= '0;
         in_frame_ff         <= 1'b0;
         payload_count_ff    <= '0;
         frame_count_ff      <= '0;
         decimation_count_ff <= '0;
         rsp_valid_ff        <= 1'b0;
      end else begin
         if (req_ch.ready) begin
            byte_valid_ff <= req_ch.valid;
         end
         sync_window_ff      <= sync_window_in;
         in_frame_ff         <= in_frame_in;
         payload_count_ff    <= payload_count_in;
         decimation_count_ff <= decimation_count_in;
         if (rsp_load) begin
            frame_count_ff <= frame_count_ff + 32'd1;
            rsp_valid_ff   <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_ch.ready && req_ch.valid) begin
         byte_ff <= req_ch.data_byte;
      end
      payload_shift_ff <= payload_shift_in;
      if (rsp_load) begin
         first_sample_ff  <= invert_first_ff ? -raw_first : raw_first;
         second_sample_ff <= invert_second_ff ? -raw_second : raw_second;
         frame_index_ff   <= frame_count_ff;
         display_point_ff <= flag;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.first_sample  = first_sample_ff;
   assign rsp_ch.second_sample = second_sample_ff;
   assign rsp_ch.frame_index   = frame_index_ff;
   assign rsp_ch.display_point = display_point_ff;

   `SWFD_ASSERT_SAME(a_count_only_in_frame, payload_count_ff != 3'd0, in_frame_ff)
   `SWFD_ASSERT_SAME(a_window_clear_in_frame, in_frame_ff, sync_window_ff == 32'd0)
   `SWFD_ASSERT_NEXT(a_hunt_after_frame, rsp_load, !in_frame_ff && rsp_valid_ff)
   `SWFD_ASSERT_NEXT(a_index_steps, rsp_load, frame_count_ff == $past(frame_count_ff) + 32'd1)
   `SWFD_ASSERT_SAME(a_no_overwrite, rsp_valid_ff && !rsp_ch.ready, !rsp_load)

endmodule

`default_nettype wire
